>>> hw/rtl/klfe_pkg.sv
`default_nettype none

package klfe_pkg;

  localparam int PIXEL_COUNT_DEFAULT = 32;
  localparam int KEY_COUNT = 50;

  localparam logic [1:0] REG_BASE_BRIGHTNESS   = 2'd0;
  localparam logic [1:0] REG_REFRESH_PERIOD_MS = 2'd1;

  localparam logic [6:0] BRIGHTNESS_RESET = 7'd100;
  localparam logic [7:0] PERIOD_RESET     = 8'd25;

  localparam logic [22:0] RECIP_25  = 23'd5368710;
  localparam logic [21:0] RECIP_125 = 22'd2147484;

  localparam logic [4:0] KEY_TABLE [KEY_COUNT] = '{
    5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30,
    5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
    5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd11, 5'd12, 5'd13, 5'd14,
    5'd15, 5'd16, 5'd17, 5'd18,
    5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10
  };

  typedef struct packed {
    logic       operation;
    logic [5:0] key_position;
    logic       key_pressed;
    logic       from_remote;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  pixel_index;
    logic [15:0] pixel_level;
    logic        last_pixel;
  } pix_t;

  typedef struct packed {
    logic        flag;
    logic [15:0] level;
  } cell_t;

  typedef struct packed {
    logic       en;
    logic [4:0] pix;
    logic       pressed;
  } key_write_t;

  typedef struct packed {
    logic [15:0] level_max;
    logic [16:0] step_rise;
    logic [13:0] step_fall;
  } steps_t;

  function automatic logic [4:0] key_to_pixel(input logic [5:0] pos);
    logic [4:0] pix;
    pix = 5'd0;
    if (pos < 6'(KEY_COUNT)) begin
      pix = KEY_TABLE[pos];
    end
    return pix;
  endfunction

  // Exact quotient by 25 for any 22-bit dividend.
  function automatic logic [17:0] div25(input logic [21:0] y);
    logic [44:0] prod;
    prod = 45'(y) * 45'(RECIP_25);
    return prod[44:27];
  endfunction

  // Exact quotient by 125 for any 21-bit dividend.
  function automatic logic [14:0] div125(input logic [20:0] z);
    logic [42:0] prod;
    prod = 43'(z) * 43'(RECIP_125);
    return prod[42:28];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/keypress_led_fade_engine_unit.sv
`default_nettype none

// Channel  Direction  Beat type  Handshake
// cmd      in         cmd_t      cmd_valid / cmd_stall
// pix      out        pix_t      pix_valid / pix_stall
// cfg      in         8-bit      cfg_we, cfg_index (no handshake)
//
// A key event yields no beat. A refresh tick rotates the ring of pixel cells once, one
// pixel per cycle in which the pix output can move, and the next command is taken once
// the last pixel has shifted; a stalled last beat does not hold it back.
// After reset and after each register write the step derivation runs through its
// PH_MAX, PH_PROD and PH_DIV phases, during which cmd_stall is high. A stalled pix
// beat holds the ring still.

module keypress_led_fade_engine_unit
  import klfe_pkg::*;
#(
  parameter int PIXEL_COUNT = PIXEL_COUNT_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire cmd_t       cmd_data,
  output logic            pix_valid,
  input  wire logic       pix_stall,
  output pix_t            pix_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int CW = $clog2(PIXEL_COUNT);
  localparam logic [CW-1:0] LAST = CW'(PIXEL_COUNT - 1);

  steps_t     steps;
  logic       busy;
  logic       active;
  logic [CW-1:0] count;
  logic       accept;
  logic       advance;
  key_write_t key_write;
  cell_t      ring [PIXEL_COUNT];
  cell_t      tail;
  logic [15:0] level_next;

  klfe_steps u_steps (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .steps    (steps),
    .busy     (busy)
  );

  klfe_update u_update (
    .head      (ring[0]),
    .steps     (steps),
    .level_next(level_next)
  );

  assign cmd_stall = busy || active;
  assign accept    = cmd_valid && !cmd_stall;
  assign advance   = active && (!pix_valid || !pix_stall);

  always_comb begin
    key_write.en      = accept && !cmd_data.operation && cmd_data.from_remote &&
                        (cmd_data.key_position < 6'(KEY_COUNT));
    key_write.pix     = key_to_pixel(cmd_data.key_position);
    key_write.pressed = cmd_data.key_pressed;
    tail.flag         = ring[0].flag;
    tail.level        = level_next;
  end

  for (genvar i = 0; i < PIXEL_COUNT; i++) begin : g_cell
    if (i == PIXEL_COUNT - 1) begin : g_tail
      klfe_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (advance),
        .key_write(key_write),
        .from_next(tail),
        .held     (ring[i])
      );
    end else begin : g_body
      klfe_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (advance),
        .key_write(key_write),
        .from_next(ring[i+1]),
        .held     (ring[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      count     <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (accept && cmd_data.operation) begin
        active <= 1'b1;
        count  <= '0;
      end
      if (advance) begin
        count <= count + 1'b1;
        if (count == LAST) begin
          active <= 1'b0;
        end
      end
      if (advance) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
    if (advance) begin
      pix_data.pixel_index <= count[4:0];
      pix_data.pixel_level <= level_next;
      pix_data.last_pixel  <= (count == LAST);
    end
  end

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_data.operation |=> active && (count == '0))
    else $error("refresh tick did not start the ring walk");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    advance && (count == LAST) |=> !active && pix_valid && pix_data.last_pixel)
    else $error("ring walk did not end on the last pixel");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (rst)
    !active |-> !advance)
    else $error("ring shifted outside a refresh tick");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    busy |-> cmd_stall)
    else $error("command accepted while steps were being derived");

  a_key_no_beat: assert property (@(posedge clk) disable iff (rst)
    accept && !cmd_data.operation && !active |=> !active)
    else $error("key event started a ring walk");

endmodule

`default_nettype wire

>>> hw/rtl/klfe_cell.sv
`default_nettype none

module klfe_cell
  import klfe_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire key_write_t key_write,
  input  wire cell_t      from_next,
  output cell_t           held
);

  cell_t cell_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_q <= '0;
    end else if (shift) begin
      cell_q <= from_next;
    end else if (key_write.en && (6'(key_write.pix) == 6'(INDEX))) begin
      cell_q.flag <= key_write.pressed;
    end
  end

  assign held = cell_q;

endmodule

`default_nettype wire

>>> hw/rtl/klfe_update.sv
`default_nettype none

module klfe_update
  import klfe_pkg::*;
(
  input  wire cell_t       head,
  input  wire steps_t      steps,
  output logic [15:0]      level_next
);

  logic [17:0] raised;
  logic [17:0] moved;

  always_comb begin
    raised = 18'(head.level) + 18'(steps.step_rise);
    if (head.flag) begin
      moved = raised;
    end else if (head.level > 16'(steps.step_fall)) begin
      moved = 18'(head.level) - 18'(steps.step_fall);
    end else begin
      moved = '0;
    end
    if (moved > 18'(steps.level_max)) begin
      level_next = steps.level_max;
    end else begin
      level_next = moved[15:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/klfe_steps.sv
`default_nettype none

module klfe_steps
  import klfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output steps_t          steps,
  output logic            busy
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MAX,
    PH_PROD,
    PH_DIV
  } phase_t;

  phase_t      phase;
  logic [6:0]  brightness;
  logic [7:0]  period;
  logic [23:0] prod;
  logic [17:0] rise_q;
  logic [14:0] fall_q;
  logic [17:0] max_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAX;
      brightness <= BRIGHTNESS_RESET;
      period     <= PERIOD_RESET;
    end else begin
      case (phase)
        PH_MAX: begin
          steps.level_max <= max_q[15:0];
          phase           <= PH_PROD;
        end
        PH_PROD: begin
          prod  <= 24'(steps.level_max) * 24'(period);
          phase <= PH_DIV;
        end
        PH_DIV: begin
          steps.step_rise <= rise_q[16:0];
          steps.step_fall <= fall_q[13:0];
          phase           <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_BRIGHTNESS: begin
            brightness <= cfg_data[6:0];
            phase      <= PH_MAX;
          end
          REG_REFRESH_PERIOD_MS: begin
            period <= cfg_data;
            phase  <= PH_MAX;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    max_q  = div25({2'b00, brightness, 13'd0});
    rise_q = div25(prod[23:2]);
    fall_q = div125(prod[23:3]);
  end

  assign busy = (phase != PH_IDLE);

endmodule

`default_nettype wire
